>>> hw/rtl/fnic_pkg.sv
// fnic_pkg: shared types and constants for the framed network interface
// transaction structs, command codes, register offsets, result and fault codes
// no dependencies
package fnic_pkg;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] offset;
		logic [31:0] write_data;
		logic [31:0] rx_word;
		logic        rx_last;
		logic [2:0]  rx_last_bytes;
	} fnic_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bus_error;
		logic [2:0]  device_fault;
		logic        irq;
		logic [2:0]  rx_result;
		logic [31:0] tx_word;
		logic        tx_valid;
		logic        tx_last;
	} fnic_out_t;

	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_RX    = 3'd2;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_PULL  = 3'd4;

	localparam logic [16:0] OFF_RIRQ   = 17'd0;
	localparam logic [16:0] OFF_WIRQ   = 17'd4;
	localparam logic [16:0] OFF_CTRL   = 17'd8;
	localparam logic [16:0] OFF_STATUS = 17'd12;
	localparam logic [16:0] RX_BASE    = 17'd32768;

	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_IRQ   = 3'd1;
	localparam logic [2:0] FLT_CTRL  = 3'd2;
	localparam logic [2:0] FLT_BUSY  = 3'd3;
	localparam logic [2:0] FLT_LEN   = 3'd4;

	localparam logic [2:0] RXR_NONE    = 3'd0;
	localparam logic [2:0] RXR_OK      = 3'd1;
	localparam logic [2:0] RXR_RUNT    = 3'd2;
	localparam logic [2:0] RXR_FRAMING = 3'd3;
	localparam logic [2:0] RXR_NOTOURS = 3'd4;
	localparam logic [2:0] RXR_TRUNC   = 3'd5;
	localparam logic [2:0] RXR_GARBAGE = 3'd6;
	localparam logic [2:0] RXR_OVERRUN = 3'd7;

	localparam logic [1:0] SEL_REG = 2'd0;
	localparam logic [1:0] SEL_RX  = 2'd1;
	localparam logic [1:0] SEL_TX  = 2'd2;

	localparam logic [15:0] MAGIC     = 16'ha4b3;
	localparam logic [15:0] BCAST     = 16'hffff;
	localparam logic [16:0] OVR_CAP   = 17'd8;
	localparam logic [16:0] COUNT_MAX = 17'h1ffff;

	localparam logic [0:0] CFG_HW_ADDRESS = 1'd0;
	localparam logic [0:0] CFG_LATENCY    = 1'd1;

endpackage

>>> hw/rtl/fnic_ram.sv
// fnic_ram: single-port word memory with byte enables, registered read
// no dependencies
module fnic_ram #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [3:0]               be,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [31:0]              wdata,
	output logic [31:0]              rdata
);

	logic [3:0][7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int b = 0; b < 4; b++) begin
				if (be[b]) begin
					mem[addr][b] <= wdata[8*b +: 8];
				end
			end
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> hw/rtl/framed_nic_with_buffers.sv
// framed_nic_with_buffers: network interface with receive and transmit buffers
// result: offered in the cycle after its transaction is accepted
// throughput: one transaction per cycle unless out_ready stalls; at most one access per ram
// reset: flags, counters, send timer and header words clear asynchronously
// buffers are not cleared; a word reads as garbage until written, no clearing pass
// depends on fnic_pkg and fnic_ram
module framed_nic_with_buffers #(
	parameter int BUF_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fnic_pkg::fnic_in_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fnic_pkg::fnic_out_t out_data,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	import fnic_pkg::*;

	localparam int BUF_WORDS = BUF_BYTES / 4;
	localparam int AW = $clog2(BUF_WORDS);
	localparam logic [16:0] BUF_LEN = 17'(BUF_BYTES);
	localparam logic [16:0] TX_BASE = RX_BASE + BUF_LEN;
	localparam logic [16:0] TX_END  = TX_BASE + BUF_LEN;

	// configuration
	logic [15:0] hw_address_q;
	logic [23:0] latency_q;

	// control state
	logic        read_irq_q, write_irq_q, promisc_q, send_busy_q;
	logic [23:0] send_timer_q;
	logic [16:0] rx_count_q;
	logic        rx_overrun_q, rx_in_frame_q;
	logic [31:0] rx_hdr1_q, rx_hdr2_q;
	logic        tx_pending_q;
	logic [12:0] tx_remaining_q;
	logic [9:0]  tx_index_q;
	// shadow of the length field in transmit word 1
	logic [15:0] tx_len_q;

	logic        read_irq_d, write_irq_d, promisc_d, send_busy_d;
	logic [23:0] send_timer_d;
	logic [16:0] rx_count_d;
	logic        rx_overrun_d, rx_in_frame_d;
	logic [31:0] rx_hdr1_d, rx_hdr2_d;
	logic        tx_pending_d;
	logic [12:0] tx_remaining_d;
	logic [9:0]  tx_index_d;
	logic [15:0] tx_len_d;

	// result stage
	logic        valid_s1;
	fnic_out_t   res_s1;
	logic [1:0]  sel_s1;
	fnic_out_t   res_d;
	logic [1:0]  sel_d;

	// ram ports
	logic           rx_we, rx_re, tx_we, tx_re;
	logic [3:0]     rx_be, tx_be;
	logic [AW-1:0]  rx_addr, tx_addr;
	logic [31:0]    rx_wdata, tx_wdata, rx_rdata, tx_rdata;

	// decode
	logic        accept;
	logic [16:0] off;
	logic [16:0] rx_rel, tx_rel;
	logic        in_rx, in_tx;

	// receive path
	logic [2:0]  nbytes;
	logic [16:0] cnt0;
	logic        ovr0;
	logic [17:0] cnt_sum;
	logic [16:0] cnt_new, cap, r;
	logic [31:0] h1, h2;
	logic [2:0]  rx_res;

	// transmit path
	logic [16:0] len_pad;

	assign accept   = in_valid && in_ready;
	// result register moves out whenever it is taken or empty
	assign in_ready = !valid_s1 || out_ready;

	assign off    = {1'b0, in_data.offset[15:2], 2'b00};
	assign rx_rel = off - RX_BASE;
	assign tx_rel = off - TX_BASE;
	assign in_rx  = (off >= RX_BASE) && (off < TX_BASE);
	assign in_tx  = (off >= TX_BASE) && (off < TX_END);

	// receive word bookkeeping; a new frame restarts the count and samples overrun
	always_comb begin
		cnt0 = rx_in_frame_q ? rx_count_q : 17'd0;
		ovr0 = rx_in_frame_q ? rx_overrun_q : read_irq_q;
		if (in_data.rx_last && in_data.rx_last_bytes >= 3'd1 && in_data.rx_last_bytes <= 3'd4) begin
			nbytes = in_data.rx_last_bytes;
		end else begin
			nbytes = 3'd4;
		end
		cnt_sum = {1'b0, cnt0} + 18'(nbytes);
		cnt_new = cnt_sum[17] ? COUNT_MAX : cnt_sum[16:0];
		h1      = (cnt0 == 17'd0) ? in_data.rx_word : rx_hdr1_q;
		h2      = (cnt0 == 17'd4) ? in_data.rx_word : rx_hdr2_q;
		cap     = ovr0 ? OVR_CAP : BUF_LEN;
		r       = (cnt_new < cap) ? cnt_new : cap;
		// frame checks in priority order
		priority if (r < 17'd8) begin
			rx_res = RXR_RUNT;
		end else if (h1[31:16] != MAGIC) begin
			rx_res = RXR_FRAMING;
		end else if (h2[15:0] != hw_address_q && h2[15:0] != BCAST && !promisc_q) begin
			rx_res = RXR_NOTOURS;
		end else if ({1'b0, h2[31:16]} > r) begin
			rx_res = RXR_TRUNC;
		end else if ({1'b0, h2[31:16]} < r) begin
			rx_res = RXR_GARBAGE;
		end else if (ovr0) begin
			rx_res = RXR_OVERRUN;
		end else begin
			rx_res = RXR_OK;
		end
	end

	assign len_pad = {1'b0, tx_len_q} + 17'd3;

	// one transaction: register updates, ram access and the result fields
	always_comb begin
		read_irq_d     = read_irq_q;
		write_irq_d    = write_irq_q;
		promisc_d      = promisc_q;
		send_busy_d    = send_busy_q;
		send_timer_d   = send_timer_q;
		rx_count_d     = rx_count_q;
		rx_overrun_d   = rx_overrun_q;
		rx_in_frame_d  = rx_in_frame_q;
		rx_hdr1_d      = rx_hdr1_q;
		rx_hdr2_d      = rx_hdr2_q;
		tx_pending_d   = tx_pending_q;
		tx_remaining_d = tx_remaining_q;
		tx_index_d     = tx_index_q;
		tx_len_d       = tx_len_q;
		res_d          = '0;
		sel_d          = SEL_REG;
		rx_we = 1'b0; rx_re = 1'b0; rx_be = 4'hf;
		tx_we = 1'b0; tx_re = 1'b0; tx_be = 4'hf;
		rx_addr  = rx_rel[AW+1:2];
		tx_addr  = tx_rel[AW+1:2];
		rx_wdata = in_data.write_data;
		tx_wdata = in_data.write_data;

		unique case (in_data.command)
			CMD_READ: begin
				priority if (in_rx) begin
					rx_re = 1'b1;
					sel_d = SEL_RX;
				end else if (in_tx) begin
					tx_re = 1'b1;
					sel_d = SEL_TX;
				end else if (off == OFF_RIRQ) begin
					res_d.read_data = {31'd0, read_irq_q};
				end else if (off == OFF_WIRQ) begin
					res_d.read_data = {31'd0, write_irq_q};
				end else if (off == OFF_CTRL) begin
					res_d.read_data = {30'd0, send_busy_q, promisc_q};
				end else if (off == OFF_STATUS) begin
					res_d.read_data = {16'd0, hw_address_q};
				end else begin
					res_d.bus_error = 1'b1;
				end
			end
			CMD_WRITE: begin
				priority if (in_rx) begin
					rx_we = 1'b1;
				end else if (in_tx) begin
					tx_we = 1'b1;
					if (tx_rel[AW+1:2] == AW'(1)) begin
						tx_len_d = in_data.write_data[31:16];
					end
				end else if (off == OFF_RIRQ || off == OFF_WIRQ) begin
					if (in_data.write_data[31:1] != 31'd0) begin
						res_d.device_fault = FLT_IRQ;
					end else if (off == OFF_RIRQ) begin
						read_irq_d = in_data.write_data[0];
					end else begin
						write_irq_d = in_data.write_data[0];
					end
				end else if (off == OFF_CTRL) begin
					if (in_data.write_data[31:2] != 30'd0) begin
						res_d.device_fault = FLT_CTRL;
					end else if (in_data.write_data[1] && send_busy_q) begin
						res_d.device_fault = FLT_BUSY;
					end else begin
						if (in_data.write_data[1]) begin
							send_busy_d  = 1'b1;
							send_timer_d = latency_q;
						end
						promisc_d = in_data.write_data[0];
					end
				end else begin
					res_d.bus_error = 1'b1;
				end
			end
			CMD_RX: begin
				rx_in_frame_d = !in_data.rx_last;
				rx_overrun_d  = ovr0;
				rx_hdr1_d     = h1;
				rx_hdr2_d     = h2;
				rx_count_d    = cnt_new;
				rx_wdata      = in_data.rx_word;
				rx_addr       = cnt0[AW+1:2];
				rx_we         = !ovr0 && (cnt0 < BUF_LEN);
				unique case (nbytes)
					3'd1:    rx_be = 4'b1000;
					3'd2:    rx_be = 4'b1100;
					3'd3:    rx_be = 4'b1110;
					default: rx_be = 4'b1111;
				endcase
				if (in_data.rx_last) begin
					res_d.rx_result = rx_res;
					if (rx_res == RXR_OK) begin
						read_irq_d = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				if (send_busy_q) begin
					if (send_timer_q <= 24'd1) begin
						send_timer_d = '0;
						send_busy_d  = 1'b0;
						if ({1'b0, tx_len_q} > BUF_LEN) begin
							res_d.device_fault = FLT_LEN;
						end else begin
							// stamp magic and source into header word 0
							tx_we          = 1'b1;
							tx_addr        = '0;
							tx_wdata       = {MAGIC, hw_address_q};
							write_irq_d    = 1'b1;
							tx_remaining_d = len_pad[14:2];
							tx_index_d     = '0;
							tx_pending_d   = len_pad[14:2] != 13'd0;
						end
					end else begin
						send_timer_d = send_timer_q - 24'd1;
					end
				end
			end
			CMD_PULL: begin
				if (tx_pending_q) begin
					tx_re            = 1'b1;
					tx_addr          = AW'(tx_index_q);
					res_d.tx_valid   = 1'b1;
					res_d.tx_last    = tx_remaining_q <= 13'd1;
					tx_index_d       = tx_index_q + 10'd1;
					tx_remaining_d   = tx_remaining_q - 13'd1;
					tx_pending_d     = tx_remaining_q != 13'd1;
				end
			end
			default: begin
			end
		endcase
		res_d.irq = read_irq_d || write_irq_d;
		// gate ram strobes by the handshake
		rx_we = rx_we && accept;
		rx_re = rx_re && accept;
		tx_we = tx_we && accept;
		tx_re = tx_re && accept;
	end

	fnic_ram #(.DEPTH(BUF_WORDS)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.be    (rx_be),
		.re    (rx_re),
		.addr  (rx_addr),
		.wdata (rx_wdata),
		.rdata (rx_rdata)
	);

	fnic_ram #(.DEPTH(BUF_WORDS)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.be    (tx_be),
		.re    (tx_re),
		.addr  (tx_addr),
		.wdata (tx_wdata),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_address_q   <= 16'd1;
			latency_q      <= 24'd2000;
			read_irq_q     <= 1'b0;
			write_irq_q    <= 1'b0;
			promisc_q      <= 1'b0;
			send_busy_q    <= 1'b0;
			send_timer_q   <= '0;
			rx_count_q     <= '0;
			rx_overrun_q   <= 1'b0;
			rx_in_frame_q  <= 1'b0;
			rx_hdr1_q      <= '0;
			rx_hdr2_q      <= '0;
			tx_pending_q   <= 1'b0;
			tx_remaining_q <= '0;
			tx_index_q     <= '0;
			tx_len_q       <= '0;
			valid_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HW_ADDRESS: hw_address_q <= cfg_data[15:0];
					CFG_LATENCY:    latency_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				read_irq_q     <= read_irq_d;
				write_irq_q    <= write_irq_d;
				promisc_q      <= promisc_d;
				send_busy_q    <= send_busy_d;
				send_timer_q   <= send_timer_d;
				rx_count_q     <= rx_count_d;
				rx_overrun_q   <= rx_overrun_d;
				rx_in_frame_q  <= rx_in_frame_d;
				rx_hdr1_q      <= rx_hdr1_d;
				rx_hdr2_q      <= rx_hdr2_d;
				tx_pending_q   <= tx_pending_d;
				tx_remaining_q <= tx_remaining_d;
				tx_index_q     <= tx_index_d;
				tx_len_q       <= tx_len_d;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// result payload; ram read data stays put while the stage is stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
			sel_s1 <= sel_d;
		end
	end

	always_comb begin
		out_data = res_s1;
		if (sel_s1 == SEL_RX) begin
			out_data.read_data = rx_rdata;
		end else if (sel_s1 == SEL_TX) begin
			out_data.read_data = tx_rdata;
		end
		if (res_s1.tx_valid) begin
			out_data.tx_word = tx_rdata;
		end
	end

	assign out_valid = valid_s1;

`ifndef SYNTHESIS
	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		!send_busy_q |-> send_timer_q == 24'd0)
		else $error("send timer running while no send is busy");

	a_pending_words: assert property (@(posedge clk) disable iff (!arst_n)
		tx_pending_q |-> tx_remaining_q != 13'd0)
		else $error("transmit queue pending with no words left");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction produced no result");

	a_tx_mux: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.tx_valid |-> sel_s1 == SEL_REG)
		else $error("pull result also marked as a buffer read");
`endif

endmodule
